/* hw/rtl/fdp_pkg.sv */
package fdp_pkg;

   // Q8.24 constants
   localparam logic signed [31:0] PI_Q      = 32'sd52707179;
   localparam logic signed [31:0] HALF_PI_Q = 32'sd26353589;
   localparam logic signed [31:0] TWO_PI_Q  = 32'sd105414357;
   localparam logic signed [31:0] CORDIC_K  = 32'sd10188014;
   localparam logic signed [31:0] Q_ONE     = 32'sd16777216;

   // reset values of the registers
   localparam logic signed [31:0] DAMPING_RST    = 32'sd838861;
   localparam logic signed [31:0] DRIVE_RATE_RST = 32'sd13421773;

   // CORDIC iteration count, capped at the table length
   localparam int CORDIC_STEPS = 24;
   localparam int ATAN_LEN     = 30;
   localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   // range reduction: offset makes any 32-bit argument nonnegative
   localparam int RED_W = 34;
   localparam logic [RED_W-1:0] RED_OFFSET = 34'd2213701497; // 21 * TWO_PI
   localparam logic [2:0] RED_TOP_SHIFT = 3'd5;

   // register select values on bit 2 of the byte address
   localparam logic ADDR_DAMPING    = 1'b0;
   localparam logic ADDR_DRIVE_RATE = 1'b1;

   // command to the shared sine / wrap unit
   typedef struct packed {
      logic start;
      logic wrap_only;
   } sin_cmd_type;

   // arctangent table, Q8.24
   function automatic logic signed [31:0] atan_q(input logic [4:0] i);
      logic signed [31:0] r;
      unique case (i)
         5'd0:  r = 32'sd13176795;
         5'd1:  r = 32'sd7778716;
         5'd2:  r = 32'sd4110060;
         5'd3:  r = 32'sd2086331;
         5'd4:  r = 32'sd1047214;
         5'd5:  r = 32'sd524118;
         5'd6:  r = 32'sd262123;
         5'd7:  r = 32'sd131069;
         5'd8:  r = 32'sd65536;
         5'd9:  r = 32'sd32768;
         5'd10: r = 32'sd16384;
         5'd11: r = 32'sd8192;
         5'd12: r = 32'sd4096;
         5'd13: r = 32'sd2048;
         5'd14: r = 32'sd1024;
         5'd15: r = 32'sd512;
         5'd16: r = 32'sd256;
         5'd17: r = 32'sd128;
         5'd18: r = 32'sd64;
         5'd19: r = 32'sd32;
         5'd20: r = 32'sd16;
         5'd21: r = 32'sd8;
         5'd22: r = 32'sd4;
         5'd23: r = 32'sd2;
         5'd24: r = 32'sd1;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/fdp_sine.sv */
module fdp_sine (
   input  logic                              clock,
   input  logic                              reset,
   input  fdp_pkg::sin_cmd_type              cmd,
   input  logic signed [fdp_pkg::RED_W-1:0]  arg,
   output logic                              done,
   output logic signed [31:0]                result
);
   import fdp_pkg::*;

   localparam logic [1:0] SN_IDLE = 2'd0;
   localparam logic [1:0] SN_RED  = 2'd1;
   localparam logic [1:0] SN_FOLD = 2'd2;
   localparam logic [1:0] SN_ROT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   wrap_ff, wrap_in;
   logic [RED_W-1:0]       u_ff, u_in;
   logic [2:0]             k_ff, k_in;
   logic [4:0]             it_ff, it_in;
   logic signed [31:0]     r_ff, r_in, cx_ff, cx_in, cy_ff, cy_in;
   logic                   done_ff, done_in;
   logic signed [31:0]     res_ff, res_in;

   logic [RED_W-1:0]       sub_val;
   logic signed [31:0]     fr, sx, sy;

   always_comb begin
      state_in = state_ff;
      wrap_in  = wrap_ff;
      u_in     = u_ff;
      k_in     = k_ff;
      it_in    = it_ff;
      r_in     = r_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      sub_val  = RED_W'(TWO_PI_Q) << k_ff;
      fr       = $signed(u_ff[31:0]);
      sx       = cx_ff >>> it_ff;
      sy       = cy_ff >>> it_ff;
      unique case (state_ff)
         SN_IDLE: begin
            if (cmd.start) begin
               u_in     = RED_W'(arg) + RED_OFFSET;
               wrap_in  = cmd.wrap_only;
               k_in     = RED_TOP_SHIFT;
               state_in = SN_RED;
            end
         end
         // restoring subtraction of TWO_PI << k, one shift per cycle
         SN_RED: begin
            if (u_ff >= sub_val) u_in = u_ff - sub_val;
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) begin
               state_in = wrap_ff ? SN_IDLE : SN_FOLD;
               if (wrap_ff) begin
                  done_in = 1'b1;
                  res_in  = $signed(u_in[31:0]);
               end
            end
         end
         // fold into [-pi/2, pi/2]
         SN_FOLD: begin
            if (fr >= PI_Q) fr = fr - TWO_PI_Q;
            if (fr > HALF_PI_Q) fr = PI_Q - fr;
            else if (fr < -HALF_PI_Q) fr = -PI_Q - fr;
            r_in     = fr;
            cx_in    = CORDIC_K;
            cy_in    = '0;
            it_in    = '0;
            state_in = SN_ROT;
         end
         // one rotation per cycle
         SN_ROT: begin
            if (r_ff >= 0) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               r_in  = r_ff - atan_q(it_ff);
            end else begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               r_in  = r_ff + atan_q(it_ff);
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(CORDIC_ITERS - 1)) begin
               state_in = SN_IDLE;
               done_in  = 1'b1;
               if (cy_in > Q_ONE) res_in = Q_ONE;
               else if (cy_in < -Q_ONE) res_in = -Q_ONE;
               else res_in = cy_in;
            end
         end
         default: state_in = SN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SN_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      wrap_ff <= wrap_in;
      u_ff    <= u_in;
      k_ff    <= k_in;
      it_ff   <= it_in;
      r_ff    <= r_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* hw/rtl/forced_damped_pendulum_step_top.sv */
// Forced damped pendulum, one semi-implicit Euler step per request.
// Request channel (req_): tdata[25:0] carries the step size dt, unsigned Q2.24.
// Response channel (rsp_): tdata holds the new angle (signed Q3.24), velocity
// (signed Q8.24) and drive phase (unsigned Q3.24). Angle and velocity persist between steps.
// CSR port (csr_, APB style): damping at 0x0, drive rate at 0x4, both
// signed Q8.24; write only while no step is in flight.
// Each step runs four multiply steps, two accumulate steps, two sines
// of CORDIC_STEPS iterations each and two wraps, then loads the response
// register, all on one multiplier and one shared reduction/CORDIC unit.
// One request is in flight at a time; the block takes no new request
// until the current step has loaded its response register.
// The response sits in an output register; the block takes the next
// request while it waits, and stalls before loading the next response
// until the previous one is taken.
// Reset: angle 0, velocity 1.0, phase 0, registers to 0.05 and 0.8.
module forced_damped_pendulum_step_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [25:0] step_size
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [26:0] angle, [58:27] velocity, [85:59] drive_phase
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fdp_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MZ   = 4'd1;
   localparam logic [3:0] ST_Z    = 4'd2;
   localparam logic [3:0] ST_SX   = 4'd3;
   localparam logic [3:0] ST_SZ   = 4'd4;
   localparam logic [3:0] ST_MV   = 4'd5;
   localparam logic [3:0] ST_V    = 4'd6;
   localparam logic [3:0] ST_MX   = 4'd7;
   localparam logic [3:0] ST_X    = 4'd8;
   localparam logic [3:0] ST_WZ   = 4'd9;
   localparam logic [3:0] ST_WX   = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   function automatic logic signed [31:0] sat32(input logic signed [41:0] a);
      if (a > 42'sd2147483647) return 32'sh7fffffff;
      if (a < -42'sd2147483648) return 32'sh80000000;
      return a[31:0];
   endfunction

   logic [3:0]          state_ff, state_in;
   logic signed [31:0]  damp_ff, rate_ff;
   logic [25:0]         dt_ff, dt_in;
   logic signed [39:0]  mp_ff, mp_in;
   logic signed [31:0]  z_ff, z_in, acc_ff, acc_in, v_ff, v_in, x_ff, x_in;
   logic signed [31:0]  ang_ff, ang_in, vel_ff, vel_in, ph_ff, ph_in;
   logic                ov_ff, ov_in;
   logic [87:0]         od_ff, od_in;

   logic signed [31:0]  mul_a, mul_b;
   logic signed [63:0]  prod;
   sin_cmd_type         scmd;
   logic signed [RED_W-1:0] sarg;
   logic                sdone;
   logic signed [31:0]  sres, a1, xw;
   logic                csr_wr;

   fdp_sine u_sine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (scmd),
      .arg    (sarg),
      .done   (sdone),
      .result (sres)
   );

   // shared multiplier, floor-shifted to Q8.24
   assign prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      dt_in    = dt_ff;
      mp_in    = mp_ff;
      z_in     = z_ff;
      acc_in   = acc_ff;
      v_in     = v_ff;
      x_in     = x_ff;
      ang_in   = ang_ff;
      vel_in   = vel_ff;
      ph_in    = ph_ff;
      ov_in    = ov_ff && !rsp_tready;
      od_in    = od_ff;
      mul_a    = $signed({6'd0, dt_ff});
      mul_b    = rate_ff;
      scmd     = '0;
      sarg     = RED_W'(ang_ff);
      a1       = sat32(-42'(mp_ff));
      xw       = sres - PI_Q;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            dt_in    = req_tdata[25:0];
            state_in = ST_MZ;
         end
         ST_MZ: begin
            mp_in    = 40'(prod >>> 24);
            state_in = ST_Z;
         end
         ST_Z: begin
            z_in       = sat32(42'(ph_ff) + 42'(mp_ff));
            mul_a      = damp_ff;
            mul_b      = vel_ff;
            mp_in      = 40'(prod >>> 24);
            scmd.start = 1'b1;
            state_in   = ST_SX;
         end
         ST_SX: if (sdone) begin
            acc_in     = sat32(42'(a1) - 42'(sres));
            scmd.start = 1'b1;
            sarg       = RED_W'(z_ff);
            state_in   = ST_SZ;
         end
         ST_SZ: if (sdone) begin
            acc_in   = sat32(42'(acc_ff) + 42'(sres));
            state_in = ST_MV;
         end
         ST_MV: begin
            mul_b    = acc_ff;
            mp_in    = 40'(prod >>> 24);
            state_in = ST_V;
         end
         ST_V: begin
            v_in     = sat32(42'(vel_ff) + 42'(mp_ff));
            state_in = ST_MX;
         end
         ST_MX: begin
            mul_b    = v_ff;
            mp_in    = 40'(prod >>> 24);
            state_in = ST_X;
         end
         ST_X: begin
            x_in           = sat32(42'(ang_ff) + 42'(mp_ff));
            scmd.start     = 1'b1;
            scmd.wrap_only = 1'b1;
            sarg           = RED_W'(z_ff);
            state_in       = ST_WZ;
         end
         ST_WZ: if (sdone) begin
            ph_in          = sres;
            scmd.start     = 1'b1;
            scmd.wrap_only = 1'b1;
            sarg           = RED_W'(x_ff) + RED_W'(PI_Q);
            state_in       = ST_WX;
         end
         ST_WX: if (sdone) begin
            ang_in   = xw;
            vel_in   = v_ff;
            state_in = ST_OUT;
         end
         // load the response register once it is free
         ST_OUT: if (!ov_ff || rsp_tready) begin
            ov_in    = 1'b1;
            od_in    = {2'b00, ph_ff[26:0], vel_ff, ang_ff[26:0]};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
         ang_ff   <= '0;
         vel_ff   <= Q_ONE;
         ph_ff    <= '0;
         damp_ff  <= DAMPING_RST;
         rate_ff  <= DRIVE_RATE_RST;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         ang_ff   <= ang_in;
         vel_ff   <= vel_in;
         ph_ff    <= ph_in;
         if (csr_wr && csr_paddr[2] == ADDR_DAMPING) damp_ff <= csr_pwdata;
         if (csr_wr && csr_paddr[2] == ADDR_DRIVE_RATE) rate_ff <= csr_pwdata;
      end
      dt_ff  <= dt_in;
      mp_ff  <= mp_in;
      z_ff   <= z_in;
      acc_ff <= acc_in;
      v_ff   <= v_in;
      x_ff   <= x_in;
      od_ff  <= od_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_DAMPING) ? damp_ff : rate_ff;

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // phase stays wrapped
   a_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[85:59] < 27'd105414357))
      else $error("drive phase out of range");

   // angle stays wrapped
   a_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[26:0]) >= -27'sd52707179)
                     && ($signed(rsp_tdata[26:0]) < 27'sd52707179))
      else $error("angle out of range");

   // sine unit only finishes while a step waits on it
   a_sdone: assert property (@(posedge clock) disable iff (reset)
      sdone |-> (state_ff == ST_SX || state_ff == ST_SZ
                 || state_ff == ST_WZ || state_ff == ST_WX))
      else $error("stray sine completion");

endmodule
